@@ hw/rtl/ala_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ala_pkg: shared definitions for the audio level autoscaler
// Widths, register indexes, reset values and the window clamp that the
// autoscaler modules share.
// ----------------------------------------------------------------------------
package ala_pkg;

    // Field and state widths.
    localparam int DATA_W    = 10;
    localparam int WLEN_W    = 7;
    localparam int AVG_W     = 11;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int CFG_IDX_W = 2;

    // History ring.
    localparam int WINDOW  = 64;
    localparam int HIST_AW = $clog2(WINDOW);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CENTER      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SIGNAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 2'd3;

    // Reset values.
    localparam logic [DATA_W-1:0] RST_CENTER      = 10'd512;
    localparam logic [DATA_W-1:0] RST_MAX_SIGNAL  = 10'd16;
    localparam logic [WLEN_W-1:0] RST_WINDOW_LEN  = 7'd64;
    localparam logic [DATA_W-1:0] RST_NOISE_FLOOR = 10'd10;
    localparam logic [DATA_W-1:0] RST_SMOOTH      = 10'd10;

    // Window length in use: zero counts as one, anything above the ring size
    // counts as the ring size.
    function automatic logic [WLEN_W-1:0] eff_window(input logic [WLEN_W-1:0] len);
        logic [WLEN_W-1:0] w;
        if (len == '0) begin
            w = WLEN_W'(1);
        end else if (len > WLEN_W'(WINDOW)) begin
            w = WLEN_W'(WINDOW);
        end else begin
            w = len;
        end
        return w;
    endfunction

endpackage

@@ hw/rtl/audio_level_autoscaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_level_autoscaler: dynamic-range display level for a microphone
//
// Input channel: i_valid / o_stall with i_sample, a raw 10-bit converter
// reading. An item is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_level, the display level in
// 0..max_signal. One result item is produced for every input item.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// registers are center, max_signal, window_len and noise_floor. Writing
// center also reloads the maximum average. Writes are taken only while idle,
// and a write on offer holds off the sample channel for that cycle.
// Processing: an item passes the write, multiply, run, average and output
// states in order, and leaves run once the scan and the divider are done.
// The history scan reads one entry per cycle from the single read port of
// the history RAM, while a serial divider produces the level one quotient
// bit per cycle alongside. One item is processed at a time; the next may
// enter while the result still waits in the output register.
// Reset: synchronous, active low. Configuration, state and valid registers
// return to their defaults; the history reads as zero until each entry is written again.
// Receiver stall: the result holds in the output register and the block
// waits before delivering the following one.
// ----------------------------------------------------------------------------
module audio_level_autoscaler
    import ala_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [DATA_W-1:0]    i_sample,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_W-1:0]    o_level,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_AVG   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Configuration registers.
    logic [DATA_W-1:0]  r_center;
    logic [DATA_W-1:0]  r_max_signal;
    logic [WLEN_W-1:0]  r_window_len;
    logic [DATA_W-1:0]  r_noise_floor;

    // Block state.
    logic [2:0]         r_state;
    logic [DATA_W-1:0]  r_smooth;
    logic [HIST_AW-1:0] r_wpos;
    logic [DATA_W-1:0]  r_min_avg;
    logic [AVG_W-1:0]   r_max_avg;
    logic [WINDOW-1:0]  r_hvalid;

    // Per-item working registers.
    logic [DATA_W-1:0]  r_gate;
    logic               r_scale_ok;
    logic [WLEN_W-1:0]  r_rd_addr;
    logic               r_rd_pend;
    logic               r_rd_hv;
    logic               r_first;
    logic [DATA_W-1:0]  r_lo;
    logic [DATA_W-1:0]  r_hi;
    logic [DATA_W-1:0]  r_q;

    // Output register.
    logic               r_o_valid;
    logic [DATA_W-1:0]  r_level;

    logic               in_acc;
    logic               cfg_acc;
    logic [DATA_W-1:0]  abs_val;
    logic [DATA_W-1:0]  gate_val;
    logic [WLEN_W-1:0]  win;
    logic [DATA_W+1:0]  smooth_sum;
    logic [WLEN_W-1:0]  wpos_inc;
    logic               scan_issue;
    logic               scan_busy;
    logic [DATA_W-1:0]  rd_val;
    logic [DATA_W-1:0]  ram_q;
    logic               div_busy;
    logic [PROD_W-1:0]  div_quo;
    logic [PROD_W-1:0]  prod_val;
    logic [AVG_W-1:0]   den_val;
    logic [AVG_W-1:0]   hi_adj;
    logic [DATA_W+6:0]  min_sum;
    logic [AVG_W+6:0]   max_sum;
    logic               out_free;

    assign in_acc   = i_valid && !o_stall;
    assign cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign o_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign win      = eff_window(r_window_len);

    // Centre, rectify and gate the incoming sample.
    always_comb begin
        abs_val  = (i_sample >= r_center) ? (i_sample - r_center) : (r_center - i_sample);
        gate_val = (abs_val <= r_noise_floor) ? '0 : (abs_val - r_noise_floor);
    end

    // Smoother and ring pointer arithmetic.
    always_comb begin
        smooth_sum = {r_smooth, 1'b0} + {2'b00, r_smooth} + {2'b00, r_gate};
        wpos_inc   = {1'b0, r_wpos} + 1'b1;
    end

    // Scaling numerator and divisor from the previous averages, handed
    // straight to the divider as it starts.
    always_comb begin
        prod_val = {{DATA_W{1'b0}}, r_max_signal} *
                   {{DATA_W{1'b0}}, (r_smooth - r_min_avg)};
        den_val  = r_max_avg - {1'b0, r_min_avg};
    end

    // History scan: one read issued per cycle while the window lasts.
    assign scan_issue = (r_state == S_RUN) && (r_rd_addr < win);
    assign scan_busy  = scan_issue || r_rd_pend;
    assign rd_val     = r_rd_hv ? ram_q : '0;

    // Range widening and damped averages.
    always_comb begin
        if ((r_hi - r_lo) < r_max_signal) begin
            hi_adj = {1'b0, r_lo} + {1'b0, r_max_signal};
        end else begin
            hi_adj = {1'b0, r_hi};
        end
        min_sum = {1'b0, r_min_avg, 6'b0} - {7'b0, r_min_avg} + {7'b0, r_lo};
        max_sum = {1'b0, r_max_avg, 6'b0} - {7'b0, r_max_avg} + {7'b0, hi_adj};
    end

    ala_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_wpos),
        .i_wdata (r_gate),
        .i_raddr (r_rd_addr[HIST_AW-1:0]),
        .o_rdata (ram_q)
    );

    ala_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL),
        .i_num   (prod_val),
        .i_den   (den_val),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center      <= RST_CENTER;
            r_max_signal  <= RST_MAX_SIGNAL;
            r_window_len  <= RST_WINDOW_LEN;
            r_noise_floor <= RST_NOISE_FLOOR;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                REG_CENTER:      r_center      <= i_cfg_data;
                REG_MAX_SIGNAL:  r_max_signal  <= i_cfg_data;
                REG_WINDOW_LEN:  r_window_len  <= i_cfg_data[WLEN_W-1:0];
                REG_NOISE_FLOOR: r_noise_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and persistent state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_smooth  <= RST_SMOOTH;
            r_wpos    <= '0;
            r_min_avg <= '0;
            r_max_avg <= {1'b0, RST_CENTER};
            r_hvalid  <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_pend <= scan_issue;
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (cfg_acc && (i_cfg_index == REG_CENTER)) begin
                        r_max_avg <= {1'b0, i_cfg_data};
                    end
                    if (in_acc) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_smooth <= smooth_sum[DATA_W+1:2];
                    r_hvalid[r_wpos] <= 1'b1;
                    if (wpos_inc >= win) begin
                        r_wpos <= '0;
                    end else begin
                        r_wpos <= wpos_inc[HIST_AW-1:0];
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (!scan_busy && !div_busy) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    r_min_avg <= min_sum[DATA_W+5:6];
                    r_max_avg <= max_sum[AVG_W+5:6];
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Per-item datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_gate <= gate_val;
        end

        // Decide whether the scaled level can be positive at all.
        if (r_state == S_MUL) begin
            r_scale_ok <= (r_smooth > r_min_avg) && (r_max_avg > {1'b0, r_min_avg});
            r_rd_addr  <= '0;
            r_first    <= 1'b1;
        end else if (scan_issue) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end

        // Track the valid bit of the entry being read.
        r_rd_hv <= r_hvalid[r_rd_addr[HIST_AW-1:0]];

        // Minimum and maximum over the returned history entries.
        if (r_rd_pend) begin
            r_first <= 1'b0;
            if (r_first || (rd_val < r_lo)) begin
                r_lo <= rd_val;
            end
            if (r_first || (rd_val > r_hi)) begin
                r_hi <= rd_val;
            end
        end

        // Clip the quotient to the output range.
        if (r_state == S_AVG) begin
            if (!r_scale_ok) begin
                r_q <= '0;
            end else if (div_quo > {{DATA_W{1'b0}}, r_max_signal}) begin
                r_q <= r_max_signal;
            end else begin
                r_q <= div_quo[DATA_W-1:0];
            end
        end

        if ((r_state == S_OUT) && out_free) begin
            r_level <= r_q;
        end
    end

    assign o_valid = r_o_valid;
    assign o_level = r_level;

endmodule

@@ hw/rtl/ala_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ala_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ala_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ala_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ala_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, for the level scaling.
// ----------------------------------------------------------------------------
module ala_div
    import ala_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [AVG_W-1:0]  i_den,
    output logic              o_busy,
    output logic [PROD_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(PROD_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [AVG_W-1:0]  r_rem;
    logic [AVG_W-1:0]  r_den;
    logic [PROD_W-1:0] r_quo;

    logic [AVG_W:0]    shifted;
    logic [AVG_W:0]    diff;
    logic              take;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb begin
        shifted = {r_rem, r_quo[PROD_W-1]};
        diff    = shifted - {1'b0, r_den};
        take    = (shifted >= {1'b0, r_den});
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(PROD_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= take ? diff[AVG_W-1:0] : shifted[AVG_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], take};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

@@ verif/audio_level_autoscaler_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_level_autoscaler_checker: level predictor and scoreboard
// Watches the sample, level and register channels of the autoscaler. It keeps
// its own copy of the registers, the smoother, the history ring and the
// damped averages, predicts the level for every sample taken, and compares
// each level delivered against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module audio_level_autoscaler_checker
    import ala_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  logic [DATA_W-1:0]    i_sample,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  logic [DATA_W-1:0]    o_level,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_flat
);

    // Register copies.
    logic [DATA_W-1:0] cfg_center;
    logic [DATA_W-1:0] cfg_max_sig;
    logic [WLEN_W-1:0] cfg_wlen;
    logic [DATA_W-1:0] cfg_noise;

    // Predictor state.
    logic [DATA_W-1:0] smooth;
    logic [DATA_W-1:0] ring [WINDOW];
    int                wr_ptr;
    logic [DATA_W-1:0] min_avg;
    logic [AVG_W-1:0]  max_avg;

    // Levels predicted but not yet delivered, oldest first.
    logic [DATA_W-1:0] expected_levels [$];

    int err_cnt;
    int chk_cnt;
    int flat_cnt;

    // Advances the predictor by one sample and returns the display level.
    function automatic logic [DATA_W-1:0] predict_level(input logic [DATA_W-1:0] s);
        int amp;
        int gated;
        int win;
        int den;
        int num;
        int q;
        int lo;
        int hi;
        int k;
        amp = (s >= cfg_center) ? int'(s) - int'(cfg_center) : int'(cfg_center) - int'(s);
        gated = (amp <= int'(cfg_noise)) ? 0 : amp - int'(cfg_noise);
        if (cfg_wlen == '0) begin
            win = 1;
        end else if (int'(cfg_wlen) > WINDOW) begin
            win = WINDOW;
        end else begin
            win = int'(cfg_wlen);
        end

        // Three-quarter smoothing of the gated amplitude.
        smooth = DATA_W'((int'(smooth) * 3 + gated) >> 2);

        // The write pointer wraps at the window in use, even if it shrank.
        if (wr_ptr >= WINDOW) begin
            wr_ptr = 0;
        end
        ring[wr_ptr] = DATA_W'(gated);
        wr_ptr++;
        if (wr_ptr >= win) begin
            wr_ptr = 0;
        end

        // Scale between the old averages; a non-positive span gives zero.
        den = int'(max_avg) - int'(min_avg);
        num = int'(cfg_max_sig) * (int'(smooth) - int'(min_avg));
        if (den <= 0) begin
            q = 0;
            flat_cnt++;
        end else begin
            q = num / den;
            if (q < 0) begin
                q = 0;
            end else if (q > int'(cfg_max_sig)) begin
                q = int'(cfg_max_sig);
            end
        end

        // Window extremes, with the span widened to at least max_signal.
        lo = int'(ring[0]);
        hi = int'(ring[0]);
        for (k = 1; k < win; k++) begin
            if (int'(ring[k]) < lo) begin
                lo = int'(ring[k]);
            end
            if (int'(ring[k]) > hi) begin
                hi = int'(ring[k]);
            end
        end
        if (hi - lo < int'(cfg_max_sig)) begin
            hi = lo + int'(cfg_max_sig);
        end

        min_avg = DATA_W'((int'(min_avg) * 63 + lo) >> 6);
        max_avg = AVG_W'((int'(max_avg) * 63 + hi) >> 6);
        return DATA_W'(q);
    endfunction

    // Track the channels at each rising edge.
    always @(posedge i_clk) begin : watch
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            cfg_center  = RST_CENTER;
            cfg_max_sig = RST_MAX_SIGNAL;
            cfg_wlen    = RST_WINDOW_LEN;
            cfg_noise   = RST_NOISE_FLOOR;
            smooth      = RST_SMOOTH;
            foreach (ring[j]) begin
                ring[j] = '0;
            end
            wr_ptr  = 0;
            min_avg = '0;
            max_avg = {1'b0, RST_CENTER};
            expected_levels.delete();
            err_cnt  = 0;
            chk_cnt  = 0;
            flat_cnt = 0;
        end else begin
            // A delivered level is matched against the oldest prediction.
            if (o_valid && !i_stall) begin
                if (expected_levels.size() == 0) begin
                    $error("level: unexpected item, actual %0d", o_level);
                    err_cnt++;
                end else begin
                    want = expected_levels.pop_front();
                    chk_cnt++;
                    if (o_level !== want) begin
                        $error("level mismatch: expected %0d, actual %0d", want, o_level);
                        err_cnt++;
                    end
                end
            end

            // Register writes; center also reloads the maximum average.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER: begin
                        cfg_center = i_cfg_data;
                        max_avg    = {1'b0, i_cfg_data};
                    end
                    REG_MAX_SIGNAL: begin
                        cfg_max_sig = i_cfg_data;
                    end
                    REG_WINDOW_LEN: begin
                        cfg_wlen = i_cfg_data[WLEN_W-1:0];
                    end
                    REG_NOISE_FLOOR: begin
                        cfg_noise = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_valid && !o_stall) begin
                expected_levels.push_back(predict_level(i_sample));
            end
        end
        o_errors  <= err_cnt;
        o_pending <= expected_levels.size();
        o_checked <= chk_cnt;
        o_flat    <= flat_cnt;
    end

endmodule

@@ verif/tb_audio_level_autoscaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_level_autoscaler: stimulus and verdict for the level autoscaler
// Drives microphone samples and register settings into the block, with random
// gaps on the sample side and random stalls on the level side, plus one long
// output hold that backs the block up. A separate checker predicts and
// compares every level; this module reports the outcome.
// ----------------------------------------------------------------------------
module tb_audio_level_autoscaler;
    import ala_pkg::*;

    localparam int DRAIN_PAD   = 100;
    localparam int HOLD_CYCLES = 800;
    localparam int QUIET_LIMIT = 4000;
    localparam int RAND_PHASES = 16;
    localparam int PHASE_ITEMS = 100;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [DATA_W-1:0]    i_sample;
    logic                 o_valid;
    logic                 i_stall;
    logic [DATA_W-1:0]    o_level;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0]    i_cfg_data;

    int err_total;
    int pending;
    int checked;
    int flat;

    int  samples_sent;
    int  settings_done;
    int  quiet_cycles = 0;
    bit  no_idle;
    bit  hold_req;

    audio_level_autoscaler dut (.*);

    audio_level_autoscaler_checker level_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_level     (o_level),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (err_total),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_flat      (flat)
    );

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycles a side waits before its next item.
    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 17));
    endfunction

    // Offers one sample after a random gap and waits until it is taken.
    task automatic send_sample(input logic [DATA_W-1:0] s);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_stall);
        samples_sent++;
    endtask

    // Waits until every predicted level has come, then lets the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Writes the registers selected by the mask, in index order.
    task automatic program_regs(input logic [3:0] mask, input logic [DATA_W-1:0] c,
                                input logic [DATA_W-1:0] ms, input logic [DATA_W-1:0] wl,
                                input logic [DATA_W-1:0] nf);
        logic [DATA_W-1:0]    vals [4];
        logic [CFG_IDX_W-1:0] regs [4];
        int k;
        vals = '{c, ms, wl, nf};
        regs = '{REG_CENTER, REG_MAX_SIGNAL, REG_WINDOW_LEN, REG_NOISE_FLOOR};
        for (k = 0; k < 4; k++) begin
            if (mask[k]) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= regs[k];
                i_cfg_data  <= vals[k];
                do @(posedge i_clk); while (!o_cfg_ready);
            end
        end
        i_cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Level side: random stalls per item, and one long hold on request.
    initial begin : level_sink
        int hold;
        i_stall <= 1'b0;
        forever begin
            do @(posedge i_clk); while (!o_valid);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            hold = draw_wait();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin : stimulus
        logic [DATA_W-1:0] corner_samples [8];
        logic [DATA_W-1:0] cur_center;
        logic [DATA_W-1:0] ms;
        logic [DATA_W-1:0] wl;
        logic [DATA_W-1:0] nf;
        logic [3:0]        mask;
        int ph;
        int n;
        int amp;
        int r;
        int v;

        samples_sent  = 0;
        settings_done = 0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_CENTER;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: full-scale codes and both sides of the noise floor.
        corner_samples = '{10'd0, 10'd1023, 10'd522, 10'd523, 10'd502, 10'd501,
                           10'h155, 10'h2AA};
        foreach (corner_samples[j]) begin
            send_sample(corner_samples[j]);
        end

        // Silence at code zero, full scale, one-entry window, no gating.
        drain();
        program_regs(4'hF, 10'd0, 10'd1023, 10'd1, 10'd0);
        send_sample(10'd1023);
        send_sample(10'd0);

        // Everything gated away; window length far above the ring size.
        drain();
        program_regs(4'hF, 10'd1023, 10'd1, 10'h3FF, 10'd1023);
        send_sample(10'd0);
        send_sample(10'd1023);

        // Zero max_signal and a zero window length.
        drain();
        program_regs(4'hF, 10'd512, 10'd0, 10'd0, 10'd10);
        send_sample(10'd0);
        send_sample(10'd1023);

        // Shrink the window below the write position, then grow it again so
        // that entries left outside the window come back into the scan.
        drain();
        program_regs(4'hF, 10'd512, 10'd16, 10'd64, 10'd10);
        for (n = 0; n < 9; n++) begin
            send_sample(DATA_W'($urandom_range(0, 1023)));
        end
        drain();
        program_regs(4'b0100, 10'd0, 10'd0, 10'd4, 10'd0);
        send_sample(10'd900);
        send_sample(10'd100);
        drain();
        program_regs(4'b0100, 10'd0, 10'd0, 10'd64, 10'd0);
        send_sample(10'd700);
        send_sample(10'd300);

        // Raise the minimum average, then drop center beneath it so that the
        // span between the averages is no longer positive.
        drain();
        program_regs(4'hF, 10'd512, 10'd16, 10'd1, 10'd0);
        for (n = 0; n < 4; n++) begin
            send_sample(10'd1023);
        end
        drain();
        program_regs(4'b0001, 10'd0, 10'd0, 10'd0, 10'd0);
        send_sample(10'd1023);
        send_sample(10'd0);

        // Random phases: fresh settings, then audio-like bursts around the
        // silence code with some uniform noise and rail hits mixed in.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            r = $urandom_range(0, 3);
            cur_center = (r == 0) ? (($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023) :
                         (r == 1) ? DATA_W'($urandom_range(0, 1023)) :
                                    DATA_W'($urandom_range(384, 640));
            r = $urandom_range(0, 3);
            ms = (r == 0) ? DATA_W'($urandom_range(0, 1023)) :
                 (r == 1) ? 10'd1023 : DATA_W'($urandom_range(1, 64));
            wl = ($urandom_range(0, 4) == 0) ? DATA_W'($urandom_range(0, 1023)) :
                                               DATA_W'($urandom_range(1, 16));
            nf = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 1023)) :
                                               DATA_W'($urandom_range(0, 40));
            mask = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
            if (ph == 0) begin
                mask = 4'hF;
            end
            program_regs(mask, cur_center, ms, wl, nf);

            // Some phases run flat out; one of them also holds the output.
            no_idle = (ph % 4 == 3) || (ph == 2);
            if (ph == 2) begin
                hold_req = 1'b1;
            end

            amp = $urandom_range(0, 511);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    v = int'(cur_center) + int'($urandom_range(0, 2 * amp)) - amp;
                    v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
                end else if (r < 90) begin
                    v = $urandom_range(0, 1023);
                end else begin
                    v = ($urandom_range(0, 1) == 0) ? 0 : 1023;
                end
                send_sample(DATA_W'(v));
            end
            no_idle = 1'b0;
        end

        drain();
        $display("Run covered %0d samples under %0d register settings; %0d levels checked.",
                 samples_sent, settings_done, checked);
        $display("Windows from one entry to full, zero and full-scale max_signal, gating, "
                 , "a long output hold, and %0d levels with a collapsed span.", flat);
        if (err_total == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
